// File: hdl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants for the timing wheel timer queue: field widths, request
// and status codes, and the parameter defaults.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int SLOTS_DEF   = 1024;
    localparam int ENTRIES_DEF = 32;
    localparam int MAXRES      = 32;
    localparam int TIME_W      = 48;
    localparam int ID_W        = 5;
    localparam int CFG_W       = 11;
    localparam int K_W         = $clog2(MAXRES + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_REMOVE  = 2'd2;
    localparam logic [1:0] REQ_NOP     = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_PAST   = 2'd2;
    localparam logic [1:0] ST_LINKED = 2'd3;

endpackage

// File: hdl/tws_slot_mem.sv
// ----------------------------------------------------------------------------
// tws_slot_mem
// Slot list store: one word per slot holding the head and tail pointers.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tws_slot_mem #(
    parameter int AW    = 10,
    parameter int DW    = 12,
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tws_rem.sv
// ----------------------------------------------------------------------------
// tws_rem
// Restoring remainder unit: reduces the start slot by the slot count in use,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tws_rem #(
    parameter int SW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_num,
    input  logic [SW:0]   i_den,
    output logic          o_done,
    output logic [SW-1:0] o_rem
);

    localparam int CW = $clog2(SW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_sh;
    logic [SW:0]   r_rem;
    logic [SW:0]   r_den;
    logic [SW:0]   trial;

    // The partial remainder stays below the divisor, so it fits SW bits.
    assign trial = {r_rem[SW-1:0], r_sh[SW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SW);
                r_sh   <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= (trial >= r_den) ? trial - r_den : trial;
                r_sh  <= r_sh << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SW-1:0];

endmodule

// File: hdl/timing_wheel_timer_queue.sv
// ----------------------------------------------------------------------------
// timing_wheel_timer_queue
// Hashed timing wheel with a fixed entry pool and per-slot FIFO lists.
// ----------------------------------------------------------------------------
// Add, remove and no-op requests pass through evaluation (S_CHECK), an optional slot
// store update (S_ADDW or S_RMW) and S_EMIT; a new request is taken only back in idle.
// An advance reads, clears and walks each drained slot (S_DRD, S_DHEAD, S_WALK)
// one entry at a time, then finishes in S_DFIN; an output stall can hold the walk.
// After reset a clearing pass over every slot empties the slot store; a
// slot count write stalls requests while the start slot is reduced.
module timing_wheel_timer_queue #(
    parameter int SLOTS   = tws_pkg::SLOTS_DEF,
    parameter int ENTRIES = tws_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [tws_pkg::ID_W-1:0]    i_entry_id,
    input  logic [tws_pkg::TIME_W-1:0]  i_expire_time,
    input  logic [tws_pkg::TIME_W-1:0]  i_now,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tws_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic                        o_clamped,
    output logic                        o_taken_valid,
    output logic [tws_pkg::ID_W-1:0]    o_taken_entry,
    output logic                        o_last
);

    localparam int EW = $clog2(ENTRIES);
    localparam int SW = $clog2(SLOTS);
    localparam int NW = SW + 1;
    localparam int PW = EW + 1;
    localparam int TW = tws_pkg::TIME_W;
    localparam int KW = tws_pkg::K_W;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_NORM  = 11'b00000000100,
        S_CHECK = 11'b00000001000,
        S_ADDW  = 11'b00000010000,
        S_RMW   = 11'b00000100000,
        S_DRD   = 11'b00001000000,
        S_DHEAD = 11'b00010000000,
        S_WALK  = 11'b00100000000,
        S_DFIN  = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } t_state;

    t_state r_state;

    logic [1:0]                 r_req;
    logic [tws_pkg::ID_W-1:0]   r_id;
    logic [TW-1:0]              r_exp;
    logic [TW-1:0]              r_now;
    logic [tws_pkg::CFG_W-1:0]  r_cfg;
    logic [TW-1:0]              r_st;
    logic [SW-1:0]              r_ss;
    logic [SW-1:0]              r_base;
    logic [SW-1:0]              r_newss;
    logic                       r_norm_pend;
    logic [SW-1:0]              r_clr;
    logic [SW-1:0]              r_slot;
    logic [NW-1:0]              r_left;
    logic [PW-1:0]              r_e;
    logic [PW-1:0]              r_pend;
    logic [KW-1:0]              r_k;
    logic                       r_cl;
    logic [1:0]                 r_status;

    // Pointer words carry a valid flag in the top bit; zero is the null link.
    logic [PW-1:0]  r_next [ENTRIES];
    logic [PW-1:0]  r_prev [ENTRIES];
    logic [SW-1:0]  r_home [ENTRIES];
    logic [ENTRIES-1:0] r_linked;

    logic                       r_o_valid;
    logic [1:0]                 r_o_status;
    logic                       r_o_cl;
    logic                       r_o_tv;
    logic [tws_pkg::ID_W-1:0]   r_o_te;
    logic                       r_o_last;

    // Combinational request evaluation.
    logic [NW-1:0]  n_use;
    logic           id_ok;
    logic [EW-1:0]  eid;
    logic           lnk;
    logic           adopt;
    logic [TW-1:0]  st_eff;
    logic [SW-1:0]  base_eff;
    logic           early;
    logic           past;
    logic [TW-1:0]  diff;
    logic           cl;
    logic [NW-1:0]  d2;
    logic [NW-1:0]  s_sum;
    logic [SW-1:0]  add_slot;
    logic [TW-1:0]  dlt;
    logic [NW-1:0]  cnt;
    logic [NW-1:0]  e_sum;
    logic [SW-1:0]  new_ss;
    logic [NW-1:0]  slot_inc;

    logic           in_acc;
    logic           out_free;
    logic           rep;
    logic           walk_go;

    logic           mem_we;
    logic [SW-1:0]  mem_waddr;
    logic [2*PW-1:0] mem_wdata;
    logic           mem_re;
    logic [SW-1:0]  mem_raddr;
    logic [2*PW-1:0] mem_rdata;
    logic [PW-1:0]  m_head;
    logic [PW-1:0]  m_tail;
    logic [PW-1:0]  e_self;
    logic [PW-1:0]  p_lnk;
    logic [PW-1:0]  nx_lnk;
    logic [EW-1:0]  ee;

    logic           rem_start;
    logic           rem_done;
    logic [SW-1:0]  rem_val;

    logic           ld;
    logic [1:0]     ld_status;
    logic           ld_cl;
    logic           ld_tv;
    logic [tws_pkg::ID_W-1:0] ld_te;
    logic           ld_last;

    t_state         n_state;

    always_comb begin
        if (r_cfg < tws_pkg::CFG_W'(2)) begin
            n_use = NW'(2);
        end else if (32'(r_cfg) > SLOTS) begin
            n_use = NW'(SLOTS);
        end else begin
            n_use = NW'(r_cfg);
        end
    end

    assign id_ok    = 32'(r_id) < ENTRIES;
    assign eid      = EW'(r_id);
    assign lnk      = id_ok && r_linked[eid];
    assign adopt    = (r_st == '0);
    assign st_eff   = adopt ? r_now : r_st;
    assign base_eff = adopt ? '0 : r_base;
    assign early    = r_now < st_eff;
    assign past     = r_exp < r_now;
    assign diff     = r_exp - st_eff;
    assign cl       = diff >= TW'(n_use);
    assign d2       = cl ? n_use - NW'(1) : NW'(diff);
    assign s_sum    = NW'(base_eff) + d2;
    assign add_slot = SW'((s_sum >= n_use) ? s_sum - n_use : s_sum);
    assign dlt      = r_now - st_eff;
    assign cnt      = (dlt >= TW'(n_use)) ? n_use : NW'(dlt) + NW'(1);
    assign e_sum    = NW'(base_eff) + cnt - NW'(1);
    assign new_ss   = SW'((e_sum >= n_use) ? e_sum - n_use : e_sum);
    assign slot_inc = NW'(r_slot) + NW'(1);

    assign m_head = mem_rdata[2*PW-1:PW];
    assign m_tail = mem_rdata[PW-1:0];
    assign e_self = {1'b1, eid};
    assign p_lnk  = r_prev[eid];
    assign nx_lnk = r_next[eid];
    assign ee     = r_e[EW-1:0];

    assign o_in_stall  = (r_state != S_IDLE) || r_norm_pend;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_o_valid || !i_out_stall;

    // A drained entry is held back one step so that the final one can carry last.
    assign rep     = r_k < KW'(tws_pkg::MAXRES);
    assign walk_go = !(rep && r_pend[EW]) || out_free;

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_slot;
        rem_start = 1'b0;
        ld        = 1'b0;
        ld_status = tws_pkg::ST_OK;
        ld_cl     = 1'b0;
        ld_tv     = 1'b0;
        ld_te     = '0;
        ld_last   = 1'b0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_norm_pend) begin
                    rem_start = 1'b1;
                    n_state   = S_NORM;
                end else if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_NORM: begin
                if (rem_done) begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                n_state = S_EMIT;
                case (r_req)
                    tws_pkg::REQ_ADD: begin
                        if (!early && !past && lnk == 1'b0 && id_ok) begin
                            mem_re    = 1'b1;
                            mem_raddr = add_slot;
                            n_state   = S_ADDW;
                        end
                    end
                    tws_pkg::REQ_ADVANCE: begin
                        if (!early) begin
                            n_state = S_DRD;
                        end
                    end
                    tws_pkg::REQ_REMOVE: begin
                        if (lnk) begin
                            mem_re    = 1'b1;
                            mem_raddr = r_home[eid];
                            n_state   = S_RMW;
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_ADDW: begin
                mem_we    = 1'b1;
                mem_wdata = {(m_tail[EW] ? m_head : e_self), e_self};
                n_state   = S_EMIT;
            end
            S_RMW: begin
                mem_we    = 1'b1;
                mem_wdata = {(p_lnk[EW] ? m_head : nx_lnk), (nx_lnk[EW] ? m_tail : p_lnk)};
                n_state   = S_EMIT;
            end
            S_DRD: begin
                mem_re  = 1'b1;
                n_state = S_DHEAD;
            end
            S_DHEAD: begin
                mem_we  = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_e[EW]) begin
                    if (walk_go && rep && r_pend[EW]) begin
                        ld    = 1'b1;
                        ld_tv = 1'b1;
                        ld_te = tws_pkg::ID_W'(r_pend[EW-1:0]);
                    end
                end else if (r_left == NW'(1)) begin
                    n_state = S_DFIN;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_DFIN: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_tv   = r_pend[EW];
                    ld_te   = r_pend[EW] ? tws_pkg::ID_W'(r_pend[EW-1:0]) : '0;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_status = r_status;
                    ld_cl     = r_cl;
                    ld_last   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cfg       <= tws_pkg::CFG_RESET;
            r_st        <= '0;
            r_ss        <= '0;
            r_base      <= '0;
            r_norm_pend <= 1'b0;
            r_linked    <= '0;
            r_k         <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_CLR) begin
                r_clr <= r_clr + SW'(1);
            end

            if (i_cfg_valid) begin
                r_cfg       <= i_cfg_data;
                r_norm_pend <= 1'b1;
            end else if (rem_start) begin
                r_norm_pend <= 1'b0;
            end
            if (r_state == S_NORM && rem_done) begin
                r_base <= rem_val;
            end

            if (r_state == S_IDLE && !r_norm_pend && in_acc) begin
                r_req <= i_req_type;
                r_id  <= i_entry_id;
                r_exp <= i_expire_time;
                r_now <= i_now;
            end

            if (r_state == S_CHECK) begin
                r_cl     <= 1'b0;
                r_status <= tws_pkg::ST_OK;
                if ((r_req == tws_pkg::REQ_ADD || r_req == tws_pkg::REQ_ADVANCE) && adopt) begin
                    r_st   <= r_now;
                    r_ss   <= '0;
                    r_base <= '0;
                end
                case (r_req)
                    tws_pkg::REQ_ADD: begin
                        r_slot <= add_slot;
                        if (early) begin
                            r_status <= tws_pkg::ST_BEFORE;
                        end else if (past) begin
                            r_status <= tws_pkg::ST_PAST;
                        end else begin
                            r_cl <= cl;
                            if (lnk || !id_ok) begin
                                r_status <= tws_pkg::ST_LINKED;
                            end
                        end
                    end
                    tws_pkg::REQ_ADVANCE: begin
                        r_slot  <= base_eff;
                        r_left  <= cnt;
                        r_newss <= new_ss;
                        r_k     <= '0;
                        r_pend  <= '0;
                        if (early) begin
                            r_status <= tws_pkg::ST_BEFORE;
                        end
                    end
                    tws_pkg::REQ_REMOVE: begin
                        r_slot <= r_home[eid];
                    end
                    default: begin
                        r_status <= tws_pkg::ST_OK;
                    end
                endcase
            end

            if (r_state == S_ADDW) begin
                r_prev[eid]   <= m_tail;
                r_next[eid]   <= '0;
                r_home[eid]   <= r_slot;
                r_linked[eid] <= 1'b1;
                if (m_tail[EW]) begin
                    r_next[m_tail[EW-1:0]] <= e_self;
                end
            end

            if (r_state == S_RMW) begin
                r_linked[eid] <= 1'b0;
                if (p_lnk[EW]) begin
                    r_next[p_lnk[EW-1:0]] <= nx_lnk;
                end
                if (nx_lnk[EW]) begin
                    r_prev[nx_lnk[EW-1:0]] <= p_lnk;
                end
            end

            if (r_state == S_DHEAD) begin
                r_e <= m_head;
            end

            if (r_state == S_WALK) begin
                if (r_e[EW]) begin
                    if (walk_go) begin
                        r_linked[ee] <= 1'b0;
                        r_e          <= r_next[ee];
                        if (rep) begin
                            r_pend <= r_e;
                            r_k    <= r_k + KW'(1);
                        end
                    end
                end else if (r_left != NW'(1)) begin
                    r_left <= r_left - NW'(1);
                    r_slot <= (slot_inc == n_use) ? '0 : SW'(slot_inc);
                end
            end

            if (r_state == S_DFIN && out_free) begin
                r_st   <= r_now;
                r_ss   <= r_newss;
                r_base <= r_newss;
            end

            if (ld) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_o_status <= ld_status;
            r_o_cl     <= ld_cl;
            r_o_tv     <= ld_tv;
            r_o_te     <= ld_te;
            r_o_last   <= ld_last;
        end
    end

    tws_slot_mem #(
        .AW    (SW),
        .DW    (2 * PW),
        .DEPTH (SLOTS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tws_rem #(
        .SW (SW)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_num   (r_ss),
        .i_den   (n_use),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_clamped     = r_o_cl;
    assign o_taken_valid = r_o_tv;
    assign o_taken_entry = r_o_te;
    assign o_last        = r_o_last;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(tws_pkg::MAXRES))
        else $error("drain report count exceeds limit");

    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_taken_valid) |-> (o_status == tws_pkg::ST_OK && !o_clamped))
        else $error("drained entry carries a non-ok status");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CHECK))
        else $error("accepted request did not enter evaluation");

    a_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_taken_valid) |-> (o_taken_entry == '0 && o_last))
        else $error("non-drain result malformed");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the timing wheel timer queue. Requests come from a queue
// and the expected results from a predictor of the wheel. Both sides idle
// and stall at random. The slot count is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NSLOT = tws_pkg::SLOTS_DEF;
    localparam int NENT  = tws_pkg::ENTRIES_DEF;
    localparam int NONE  = -1;
    localparam logic [tws_pkg::TIME_W-1:0] TMAX = {tws_pkg::TIME_W{1'b1}};

    typedef struct packed {
        logic [1:0]                 kind;
        logic [tws_pkg::ID_W-1:0]   id;
        logic [tws_pkg::TIME_W-1:0] expire;
        logic [tws_pkg::TIME_W-1:0] now;
    } t_timer_req;

    typedef struct packed {
        logic [1:0]               status;
        logic                     clamped;
        logic                     taken_valid;
        logic [tws_pkg::ID_W-1:0] taken_entry;
        logic                     last;
    } t_timer_res;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [1:0]                 i_req_type = tws_pkg::REQ_NOP;
    logic [tws_pkg::ID_W-1:0]   i_entry_id = '0;
    logic [tws_pkg::TIME_W-1:0] i_expire_time = '0;
    logic [tws_pkg::TIME_W-1:0] i_now = '0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [tws_pkg::CFG_W-1:0]  i_cfg_data = tws_pkg::CFG_RESET;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_status;
    logic                       o_clamped;
    logic                       o_taken_valid;
    logic [tws_pkg::ID_W-1:0]   o_taken_entry;
    logic                       o_last;

    timing_wheel_timer_queue DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_timer_req request_q[$];
    t_timer_res due_results[$];
    bit         failed = 1'b0;
    bit         quiet = 1'b0;

    // Wheel model state.
    logic [tws_pkg::CFG_W-1:0]  slot_cfg = tws_pkg::CFG_RESET;
    logic [tws_pkg::TIME_W-1:0] wheel_start = '0;
    int                         wheel_base = 0;
    int                         head[NSLOT];
    int                         tail[NSLOT];
    int                         nxt[NENT];
    int                         prv[NENT];
    bit                         linked[NENT];
    int                         home[NENT];

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            head[s] = NONE;
            tail[s] = NONE;
        end
        for (int e = 0; e < NENT; e++) begin
            nxt[e] = NONE;
            prv[e] = NONE;
            linked[e] = 1'b0;
            home[e] = 0;
        end
    end

    function automatic t_timer_res mk(logic [1:0] st, logic cl, logic tv,
                                      logic [tws_pkg::ID_W-1:0] te, logic lst);
        t_timer_res r;
        r.status = st;
        r.clamped = cl;
        r.taken_valid = tv;
        r.taken_entry = te;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_wheel(t_timer_req r);
        int n;
        longint unsigned span;
        int slot;
        bit cl;
        int e, p, x, k, s, guard;
        n = (slot_cfg < 2) ? 2 : ((slot_cfg > NSLOT) ? NSLOT : int'(slot_cfg));
        if (r.kind == tws_pkg::REQ_ADD || r.kind == tws_pkg::REQ_ADVANCE) begin
            if (wheel_start == 0) begin
                wheel_start = r.now;
                wheel_base = 0;
            end
            if (r.now < wheel_start) begin
                due_results.push_back(mk(tws_pkg::ST_BEFORE, 0, 0, 0, 1));
                return;
            end
        end
        case (r.kind)
            tws_pkg::REQ_ADD: begin
                if (r.expire < r.now) begin
                    due_results.push_back(mk(tws_pkg::ST_PAST, 0, 0, 0, 1));
                    return;
                end
                span = r.expire - wheel_start;
                cl = 1'b0;
                if (span >= n) begin
                    span = n - 1;
                    cl = 1'b1;
                end
                slot = int'(((wheel_base % n) + span) % n);
                e = r.id;
                if (e >= NENT || linked[e]) begin
                    due_results.push_back(mk(tws_pkg::ST_LINKED, cl, 0, 0, 1));
                    return;
                end
                // Append at the tail so the slot drains in arrival order.
                prv[e] = tail[slot];
                nxt[e] = NONE;
                if (tail[slot] != NONE) nxt[tail[slot]] = e;
                else head[slot] = e;
                tail[slot] = e;
                linked[e] = 1'b1;
                home[e] = slot;
                due_results.push_back(mk(tws_pkg::ST_OK, cl, 0, 0, 1));
            end
            tws_pkg::REQ_ADVANCE: begin
                span = r.now - wheel_start + 1;
                if (span > n) span = n;
                k = 0;
                for (int i = 0; i < int'(span); i++) begin
                    s = (wheel_base % n + i) % n;
                    e = head[s];
                    guard = 0;
                    while (e != NONE && guard < NENT) begin
                        x = nxt[e];
                        nxt[e] = NONE;
                        prv[e] = NONE;
                        linked[e] = 1'b0;
                        home[e] = 0;
                        if (k < tws_pkg::MAXRES) begin
                            due_results.push_back(mk(tws_pkg::ST_OK, 0, 1,
                                                     e[tws_pkg::ID_W-1:0], 0));
                            k++;
                        end
                        e = x;
                        guard++;
                    end
                    head[s] = NONE;
                    tail[s] = NONE;
                end
                wheel_base = int'((wheel_base % n + span - 1) % n);
                wheel_start = r.now;
                if (k == 0) due_results.push_back(mk(tws_pkg::ST_OK, 0, 0, 0, 1));
                else due_results[$].last = 1'b1;
            end
            default: begin
                e = r.id;
                if (r.kind == tws_pkg::REQ_REMOVE && e < NENT && linked[e]) begin
                    s = home[e];
                    p = prv[e];
                    x = nxt[e];
                    if (p != NONE) nxt[p] = x; else head[s] = x;
                    if (x != NONE) prv[x] = p; else tail[s] = p;
                    nxt[e] = NONE;
                    prv[e] = NONE;
                    linked[e] = 1'b0;
                    home[e] = 0;
                end
                due_results.push_back(mk(tws_pkg::ST_OK, 0, 0, 0, 1));
            end
        endcase
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_wheel({i_req_type, i_entry_id, i_expire_time, i_now});
            if (!i_in_valid || !o_in_stall) begin
                if (request_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
                    i_req_type <= request_q[0].kind;
                    i_entry_id <= request_q[0].id;
                    i_expire_time <= request_q[0].expire;
                    i_now <= request_q[0].now;
                    void'(request_q.pop_front());
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_timer_res want, got;
        if (i_rst_n) begin
            i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 23);
            if (o_out_valid && !i_out_stall) begin
                got = mk(o_status, o_clamped, o_taken_valid, o_taken_entry, o_last);
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    failed = 1'b1;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        $display({"%0t: result mismatch, expected st=%0d cl=%0b tv=%0b ",
                                  "te=%0d last=%0b, actual st=%0d cl=%0b tv=%0b te=%0d ",
                                  "last=%0b"},
                                 $time, want.status, want.clamped, want.taken_valid,
                                 want.taken_entry, want.last, got.status, got.clamped,
                                 got.taken_valid, got.taken_entry, got.last);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    logic [tws_pkg::TIME_W-1:0] t_ms = 48'd100;

    task automatic queue_req(logic [1:0] kind, int id,
                             logic [tws_pkg::TIME_W-1:0] expire,
                             logic [tws_pkg::TIME_W-1:0] now);
        t_timer_req r;
        r.kind = kind;
        r.id = id[tws_pkg::ID_W-1:0];
        r.expire = expire;
        r.now = now;
        request_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (request_q.size() > 0 || i_in_valid || due_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_slot_count(logic [tws_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        slot_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int count);
        int pick;
        logic [tws_pkg::TIME_W-1:0] far;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                queue_req(tws_pkg::REQ_ADD, $urandom_range(0, 31),
                          t_ms + $urandom_range(0, 12), t_ms);
            end else if (pick < 65) begin
                t_ms += $urandom_range(0, 4);
                queue_req(tws_pkg::REQ_ADVANCE, $urandom_range(0, 31),
                          tws_pkg::TIME_W'({$urandom, $urandom}), t_ms);
            end else if (pick < 80) begin
                queue_req(tws_pkg::REQ_REMOVE, $urandom_range(0, 31),
                          tws_pkg::TIME_W'({$urandom, $urandom}),
                          tws_pkg::TIME_W'({$urandom, $urandom}));
            end else begin
                // Noise: wild times, expiries already past, stale clocks and no-ops.
                far = tws_pkg::TIME_W'({$urandom, $urandom});
                case ($urandom_range(0, 3))
                    0: queue_req(tws_pkg::REQ_ADD, $urandom_range(0, 31),
                                 far | far >> 1, far >> 1);
                    1: queue_req(tws_pkg::REQ_ADD, $urandom_range(0, 31), t_ms - 1, t_ms);
                    2: queue_req(2'($urandom_range(0, 1)), $urandom_range(0, 31),
                                 t_ms, t_ms - $urandom_range(1, 50));
                    default: queue_req(tws_pkg::REQ_NOP, $urandom_range(0, 31), far, ~far);
                endcase
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the reset slot count.
        queue_req(tws_pkg::REQ_NOP, 0, TMAX, TMAX);
        queue_req(tws_pkg::REQ_ADD, 0, 0, 0);
        queue_req(tws_pkg::REQ_ADVANCE, 0, 0, 0);
        queue_req(tws_pkg::REQ_ADD, 1, TMAX, 100);
        queue_req(tws_pkg::REQ_ADD, 1, 105, 100);
        queue_req(tws_pkg::REQ_ADD, 2, 99, 100);
        queue_req(tws_pkg::REQ_REMOVE, 2, 0, 0);
        queue_req(tws_pkg::REQ_ADD, 4, 103, 100);
        queue_req(tws_pkg::REQ_ADD, 5, 103, 100);
        queue_req(tws_pkg::REQ_ADD, 6, 103, 100);
        queue_req(tws_pkg::REQ_ADD, 31, 100, 100);
        queue_req(tws_pkg::REQ_REMOVE, 5, 0, 0);
        queue_req(tws_pkg::REQ_ADVANCE, 0, 0, 103);
        queue_req(tws_pkg::REQ_ADVANCE, 0, 0, 50);
        queue_req(tws_pkg::REQ_ADD, 7, 60, 50);
        queue_req(tws_pkg::REQ_REMOVE, 1, 0, 0);
        queue_req(tws_pkg::REQ_ADD, 8, 104, 104);
        queue_req(tws_pkg::REQ_ADVANCE, 31, TMAX, 104);
        t_ms = 104;
        wait_idle();

        write_slot_count(11'd2);
        random_requests(40);
        wait_idle();

        write_slot_count(11'd0);
        quiet = 1'b1;
        random_requests(30);
        wait_idle();
        quiet = 1'b0;

        write_slot_count(11'h7FF);
        random_requests(30);
        wait_idle();

        write_slot_count(11'd7);
        random_requests(40);
        wait_idle();

        write_slot_count(11'd1024);
        random_requests(20);
        wait_idle();

        repeat (50) @(posedge i_clk);
        if (!failed && due_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
